/* hw/rtl/tzi_pkg.sv */
// shared types and constants for the trapezoid integrator
package tzi_pkg;

   localparam int DEF_MAX_STEPS = 65536;
   localparam int DEF_FRAC_BITS = 24;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int INTEGRAL_W    = 31;

   localparam logic [INTEGRAL_W-1:0] SAT_MAX = '1;

   typedef struct packed {
      logic signed [DATA_W-1:0] lower_bound;
      logic signed [DATA_W-1:0] upper_bound;
      logic signed [DATA_W-1:0] step_width;
   } req_type;

   typedef struct packed {
      logic [INTEGRAL_W-1:0] integral;
      logic                  step_overflow;
   } rsp_type;

endpackage

/* hw/rtl/tzi_mul.sv */
// registered 32 by 32 unsigned multiplier shared by squaring and scaling
module tzi_mul (
   input  logic                        clock,
   input  logic [tzi_pkg::DATA_W-1:0]  a,
   input  logic [tzi_pkg::DATA_W-1:0]  b,
   output logic [tzi_pkg::PROD_W-1:0]  prod
);
   import tzi_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(a) * PROD_W'(b);
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/tzi_div.sv */
// restoring divider, one quotient bit per cycle, numerator fixed at 4 in fixed point
module tzi_div #(
   parameter int FRAC_BITS = tzi_pkg::DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63-FRAC_BITS:0]    den,
   output logic                     done,
   output logic [FRAC_BITS+2:0]     quot
);
   import tzi_pkg::*;

   localparam int DEN_W = PROD_W - FRAC_BITS;
   localparam int Q_W   = FRAC_BITS + 3;
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh, diff;

   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      diff    = rem_sh - {1'b0, den_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // upper numerator bits, always below the divisor
         rem_in  = DEN_W'(1) << (FRAC_BITS - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(Q_W);
      end else if (cnt_ff != '0) begin
         if (!diff[DEN_W]) begin
            rem_in  = diff[DEN_W-1:0];
            quot_in = {quot_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DEN_W-1:0];
            quot_in = {quot_ff[Q_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* hw/rtl/trapezoid_integrator.sv */
// Trapezoid-rule integrator of 4/(1+x^2): one request in, one result out. Each sample
// of the curve is squared on the shared multiplier and then divided in the bit-serial
// divider at one quotient bit a cycle, and every sample but the lower end then passes
// the loop test. n, the count of interior samples, is at most MAX_STEPS; a request
// with a non-positive step or a lower bound not below the upper bound goes straight
// to the result step without taking a sample. busy is high from acceptance until the
// result strobe; the strobe rsp_valid lasts one cycle and cannot be stalled, so the
// receiver must take the result when it appears.
module trapezoid_integrator #(
   parameter int MAX_STEPS = tzi_pkg::DEF_MAX_STEPS,
   parameter int FRAC_BITS = tzi_pkg::DEF_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tzi_pkg::req_type req_data,
   output logic             rsp_valid,
   output tzi_pkg::rsp_type rsp_data
);
   import tzi_pkg::*;

   localparam int DEN_W = PROD_W - FRAC_BITS;
   localparam int Q_W   = FRAC_BITS + 3;
   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int SUM_W = Q_W + CNT_W;
   localparam int ACC_W = PROD_W + DATA_W;
   localparam int X_W   = DATA_W + 2;
   localparam int T_W   = DATA_W + 3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_DIV_GO, ST_DIV_WAIT, ST_ACCUM, ST_TEST,
      ST_SCALE_LO, ST_SCALE_HI, ST_SCALE_ADD, ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      PH_END_LO, PH_END_HI, PH_INNER
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in, hi_ff, hi_in, step_ff, step_in;
   logic signed [X_W-1:0]  x_ff, x_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic                   ovf_ff, ovf_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]      mul_a, mul_b, x_lo, ax;
   logic [PROD_W-1:0]      mul_prod, sum_pad;
   logic                   div_start, div_done;
   logic [DEN_W-1:0]       div_den;
   logic [Q_W-1:0]         div_quot;
   logic signed [T_W-1:0]  probe;
   logic [ACC_W-1:0]       scaled;

   tzi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   tzi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      x_lo      = x_ff[DATA_W-1:0];
      ax        = x_lo[DATA_W-1] ? (~x_lo + DATA_W'(1)) : x_lo;
      sum_pad   = PROD_W'(sum_ff);
      div_den   = DEN_W'(mul_prod >> FRAC_BITS) + (DEN_W'(1) << FRAC_BITS);
      div_start = (state_ff == ST_DIV_GO);
      probe     = T_W'(x_ff) + T_W'(step_ff >>> 1);
      scaled    = acc_ff >> FRAC_BITS;

      mul_a = ax;
      mul_b = ax;
      if (state_ff == ST_SCALE_LO) begin
         mul_a = sum_pad[DATA_W-1:0];
         mul_b = step_ff;
      end else if (state_ff == ST_SCALE_HI) begin
         mul_a = sum_pad[PROD_W-1:DATA_W];
         mul_b = step_ff;
      end

      state_in     = state_ff;
      phase_in     = phase_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lo_in   = req_data.lower_bound;
               hi_in   = req_data.upper_bound;
               step_in = req_data.step_width;
               x_in    = X_W'(req_data.lower_bound);
               n_in    = '0;
               ovf_in  = 1'b0;
               acc_in  = '0;
               phase_in = PH_END_LO;
               if (req_data.step_width <= 0 ||
                   req_data.lower_bound >= req_data.upper_bound) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE:   state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            case (phase_ff)
               PH_END_LO: begin
                  sum_in   = SUM_W'(div_quot);
                  x_in     = X_W'(hi_ff);
                  phase_in = PH_END_HI;
                  state_in = ST_SQUARE;
               end
               PH_END_HI: begin
                  sum_in   = (sum_ff + SUM_W'(div_quot)) >> 1;
                  x_in     = X_W'(lo_ff) + X_W'(step_ff);
                  phase_in = PH_INNER;
                  state_in = ST_TEST;
               end
               default: begin
                  sum_in   = sum_ff + SUM_W'(div_quot);
                  n_in     = n_ff + CNT_W'(1);
                  x_in     = x_ff + X_W'(step_ff);
                  state_in = ST_TEST;
               end
            endcase
         end
         ST_TEST: begin
            if (probe < T_W'(hi_ff)) begin
               if (n_ff == CNT_W'(MAX_STEPS)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_SCALE_LO;
               end else begin
                  state_in = ST_SQUARE;
               end
            end else begin
               state_in = ST_SCALE_LO;
            end
         end
         ST_SCALE_LO: state_in = ST_SCALE_HI;
         ST_SCALE_HI: begin
            // low partial product is out of the multiplier now
            acc_in   = ACC_W'(mul_prod);
            state_in = ST_SCALE_ADD;
         end
         ST_SCALE_ADD: begin
            acc_in   = acc_ff + {mul_prod, {DATA_W{1'b0}}};
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.step_overflow = ovf_ff;
            if (|scaled[ACC_W-1:INTEGRAL_W]) begin
               rsp_data_in.integral = SAT_MAX;
            end else begin
               rsp_data_in.integral = scaled[INTEGRAL_W-1:0];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_END_LO;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      step_ff     <= step_in;
      x_ff        <= x_in;
      sum_ff      <= sum_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not make the block busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(state_ff == ST_RESULT))
      else $error("result strobe outside the result step");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished while not awaited");

   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_overflow |-> n_ff == CNT_W'(MAX_STEPS))
      else $error("step overflow flagged below the step limit");

endmodule

/* tb/tb_trapezoid_integrator.sv */
// self-checking testbench for the trapezoid integrator: directed requests, then random bursts
`timescale 1ns / 100ps

module tb;
   import tzi_pkg::*;

   // default step limit; requests that reach it are few and run long
   localparam int STEP_LIMIT     = DEF_MAX_STEPS;
   localparam int FRAC           = DEF_FRAC_BITS;
   localparam int RANDOM_ITEMS   = 75;
   localparam int DIRECTED_COUNT = 25;
   localparam int LONGEST_ITEM   = (STEP_LIMIT + 2) * (FRAC + 7) + STEP_LIMIT + 6;
   localparam int WATCHDOG_LIMIT = 10 * (LONGEST_ITEM + 40);
   localparam logic [63:0] SAT_LIMIT = 64'(SAT_MAX);
   localparam longint SPAN_MAX   = 64'h0000_0000_FFFF_FFFF;
   localparam rsp_type ZERO_RESULT = '{integral: '0, step_overflow: 1'b0};

   typedef struct {
      req_type stim;
      bit      typed;
      rsp_type want;
   } case_row;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type expected_results[$];
   rsp_type oldest;
   int      mismatch_count = 0;
   int      idle_cycles = 0;

   // zero rows are typed in, the rest go through the predictor
   case_row directed_rows [DIRECTED_COUNT] = '{
      '{'{32'h0000_0000, 32'h0100_0000, 32'h0000_0000}, 1'b1, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0100_0000, 32'hFFFF_FFFF}, 1'b1, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0100_0000, 32'h8000_0000}, 1'b1, ZERO_RESULT},
      '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, ZERO_RESULT},
      '{'{32'h0100_0000, 32'h0000_0000, 32'h0010_0000}, 1'b1, ZERO_RESULT},
      '{'{32'h0100_0000, 32'h0100_0000, 32'h0010_0000}, 1'b1, ZERO_RESULT},
      '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 1'b1, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0100_0000, 32'h0010_0000}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0100_0000, 32'h0004_0000}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0100_0000, 32'h0002_0000}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0041_0000, 32'h0001_0000}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0042_0000, 32'h0001_0000}, 1'b0, ZERO_RESULT},
      '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, ZERO_RESULT},
      '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0100_0000}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0000_0001, 32'h0000_0001}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h0000_0002, 32'h0000_0001}, 1'b0, ZERO_RESULT},
      '{'{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001}, 1'b0, ZERO_RESULT},
      '{'{32'h8000_0000, 32'h8000_0001, 32'h0000_0001}, 1'b0, ZERO_RESULT},
      '{'{32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0001}, 1'b0, ZERO_RESULT},
      '{'{32'h7FFF_FF00, 32'h7FFF_FFFF, 32'h0000_0040}, 1'b0, ZERO_RESULT},
      '{'{32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, ZERO_RESULT},
      '{'{32'hFF00_0000, 32'h0100_0000, 32'h0020_0000}, 1'b0, ZERO_RESULT},
      '{'{32'hFE00_0000, 32'hFF00_0000, 32'h0020_0000}, 1'b0, ZERO_RESULT},
      '{'{32'hFF00_0000, 32'h0100_0000, 32'h7FFF_FFFF}, 1'b0, ZERO_RESULT},
      '{'{32'h8000_0000, 32'h8100_0000, 32'h0010_0000}, 1'b0, ZERO_RESULT}
   };

   trapezoid_integrator #(
      .MAX_STEPS(STEP_LIMIT),
      .FRAC_BITS(FRAC)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // 4/(1+x^2) in fixed point, square taken exactly before truncation
   function automatic logic [63:0] curve_value(input longint x);
      logic [63:0] mag;
      logic [63:0] den;
      mag = (x < 0) ? -x : x;
      den = ((mag * mag) >> FRAC) + (64'd1 << FRAC);
      return (64'd4 << (2 * FRAC)) / den;
   endfunction

   function automatic rsp_type predict_integral(input req_type r);
      longint      lo;
      longint      hi;
      longint      h;
      longint      half;
      longint      x;
      logic [63:0] sum;
      logic [63:0] hu;
      logic [63:0] q;
      logic [63:0] frac_part;
      logic [63:0] total;
      int          n;
      rsp_type     res;
      res = ZERO_RESULT;
      lo  = longint'(signed'(r.lower_bound));
      hi  = longint'(signed'(r.upper_bound));
      h   = longint'(signed'(r.step_width));
      if (h <= 0 || lo >= hi) return res;
      sum  = (curve_value(lo) + curve_value(hi)) >> 1;
      half = h / 2;
      x    = lo + h;
      n    = 0;
      while (x + half < hi) begin
         if (n >= STEP_LIMIT) begin
            res.step_overflow = 1'b1;
            break;
         end
         sum += curve_value(x);
         n++;
         x += h;
      end
      // split the sum so that the product cannot wrap before saturation
      hu        = h;
      q         = sum >> FRAC;
      frac_part = ((sum & ((64'd1 << FRAC) - 1)) * hu) >> FRAC;
      if (q != 0 && hu > SAT_LIMIT / q) begin
         total = SAT_LIMIT;
      end else begin
         total = q * hu + frac_part;
         if (total > SAT_LIMIT) total = SAT_LIMIT;
      end
      res.integral = total[INTEGRAL_W-1:0];
      return res;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      longint      h;
      longint      span;
      longint      lo;
      int unsigned n;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r.lower_bound = $urandom;
      r.upper_bound = $urandom;
      r.step_width  = $urandom;
      // raw noise
      if (pick < 10) return r;
      // requests that must come back as zero
      if (pick < 20) begin
         if (pick == 10) begin
            r.step_width = '0;
         end else if (pick < 15) begin
            r.step_width = {1'b1, r.step_width[DATA_W-2:0]};
         end else if (pick == 19) begin
            r.upper_bound = r.lower_bound;
         end else if (r.lower_bound < r.upper_bound) begin
            {r.lower_bound, r.upper_bound} = {r.upper_bound, r.lower_bound};
         end
         return r;
      end
      // well-formed interval with a chosen number of interior samples
      h = longint'($urandom >> $urandom_range(1, 31));
      if (h == 0) h = 1;
      if ($urandom_range(0, 31) == 0) n = $urandom_range(STEP_LIMIT - 2, STEP_LIMIT + 4);
      else n = $urandom_range(0, 24);
      span = longint'(n + 1) * h - longint'($urandom_range(0, 32'(h - 1)));
      if (span > SPAN_MAX) span = SPAN_MAX;
      lo = longint'($urandom_range(0, 32'(SPAN_MAX - span))) - 64'sh8000_0000;
      r.lower_bound = lo[31:0];
      r.upper_bound = 32'(lo + span);
      r.step_width  = h[31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type want);
      $display("%0t: %s: integral %h overflow %b, expected integral %h overflow %b",
               $time, what, got.integral, got.step_overflow, want.integral,
               want.step_overflow);
      mismatch_count++;
   endtask

   // start stays high when the next request follows at once
   task automatic issue(input req_type r, input rsp_type want);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(want);
   endtask

   task automatic hold_off(input bit drain);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (!drain && pick < 4) return;
      start <= 1'b0;
      if (drain || pick == 9) begin
         do @(posedge clock); while (expected_results.size() != 0);
      end else begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   initial begin
      int      sent;
      int      burst;
      req_type r;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].stim,
               directed_rows[i].typed ? directed_rows[i].want
                                      : predict_integral(directed_rows[i].stim));
         hold_off(1'b0);
      end
      hold_off(1'b1);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            r = random_request();
            issue(r, predict_integral(r));
            sent++;
         end
         hold_off(1'b0);
      end

      hold_off(1'b1);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[trapezoid_integrator] OK");
      end else begin
         $display("[trapezoid_integrator] ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding", rsp_data, ZERO_RESULT);
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_data.integral !== oldest.integral)
               report_mismatch("integral wrong", rsp_data, oldest);
            if (rsp_data.step_overflow !== oldest.step_overflow)
               report_mismatch("step overflow flag wrong", rsp_data, oldest);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[trapezoid_integrator] ERROR");
         $finish;
      end
   end

endmodule

/* trapezoid_integrator.f */
hw/rtl/tzi_pkg.sv
hw/rtl/tzi_mul.sv
hw/rtl/tzi_div.sv
hw/rtl/trapezoid_integrator.sv
tb/tb_trapezoid_integrator.sv
